[rtl/assert_macros.svh]
// Assertion helpers shared by the RTL files of the deframer.
// Synthesis builds see empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every rising edge outside reset.
`define SPD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition in the current cycle implies a consequence in the next cycle.
`define SPD_ASSERT_NEXT(lbl, clk, rst_n, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error(msg);

`else

`define SPD_ASSERT(lbl, clk, rst_n, prop, msg)
`define SPD_ASSERT_NEXT(lbl, clk, rst_n, cond, cons, msg)

`endif

`endif

[rtl/spd_pkg.sv]
package spd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned WordW = 16;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [WordW-1:0] SyncChecksummedReset = 16'hC1AF;
  localparam logic [WordW-1:0] SyncPlainReset = 16'hC1AE;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegSyncChecksummed = 1'b0;
  localparam logic [CfgIdxW-1:0] RegSyncPlain = 1'b1;

  // Header byte positions.
  localparam logic [1:0] HdrType = 2'd0;
  localparam logic [1:0] HdrLength = 2'd1;
  localparam logic [1:0] HdrSumLow = 2'd2;
  localparam logic [1:0] HdrSumHigh = 2'd3;

  typedef enum logic [2:0] {
    PHASE_HUNT    = 3'b001,
    PHASE_HEADER  = 3'b010,
    PHASE_PAYLOAD = 3'b100
  } phase_t;

  // One result as it travels through the output stage.
  typedef struct packed {
    logic             payload_valid;
    logic [ByteW-1:0] payload_byte;
    logic [ByteW-1:0] packet_type;
    logic [ByteW-1:0] packet_length;
    logic             frame_end;
    logic             frame_status;
    logic             had_checksum;
  } res_t;

endpackage

[rtl/spd_skid.sv]
`include "assert_macros.svh"

// Two-entry output stage: an output register plus a skid register, so the
// upstream stall is a registered signal and a new request can enter every
// cycle while the receiver keeps up.
module spd_skid (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  spd_pkg::res_t push_data,
  output logic          full,
  output logic          out_valid,
  input  logic          out_stall,
  output spd_pkg::res_t out_data
);

  logic          out_valid_r, out_valid_nxt;
  logic          skid_valid_r, skid_valid_nxt;
  spd_pkg::res_t out_data_r, out_data_nxt;
  spd_pkg::res_t skid_data_r, skid_data_nxt;
  logic          take;

  assign take = out_valid_r && !out_stall;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || take) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = push;
        out_data_nxt  = push_data;
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The skid register only fills behind a waiting output register.
  `SPD_ASSERT(a_skid_behind_out, clk, rst_n, !skid_valid_r || out_valid_r,
    "skid entry held while output register is empty")
  // A push is never offered while the skid register is occupied.
  `SPD_ASSERT(a_no_push_when_full, clk, rst_n, !(push && skid_valid_r),
    "push while output stage is full")

endmodule

[rtl/sync_packet_deframer.sv]
// Byte-serial packet deframer.
// The input channel (in_valid, in_stall, in_rx_byte) carries one received
// byte per request. While hunting, the block pairs the previous byte (low
// half) with the current byte (high half) and compares the word with the two
// sync registers. A checksummed sync is followed by type, length and a
// little-endian 16-bit byte sum; a plain sync by type and length only. Then
// come length payload bytes, each passed out with out_payload_valid set.
// Every accepted byte yields exactly one result request on the output
// channel, with frame_end and frame_status marking the closing byte.
// Each accepted byte's result is registered in the output stage before it
// shows on out_valid; one byte is accepted per cycle while in_stall is low.
// When the receiver raises out_stall, results queue in the two-entry output
// stage and in_stall rises only once both entries hold results.
// Reset (synchronous, rst_n low) returns to hunting with all state cleared
// and the sync registers at 0xC1AF and 0xC1AE. cfg_we writes register
// cfg_index (0 checksummed sync, 1 plain sync) at the next rising edge.
`include "assert_macros.svh"

module sync_packet_deframer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [spd_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [spd_pkg::WordW-1:0]     cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [spd_pkg::ByteW-1:0]     in_rx_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_payload_valid,
  output logic [spd_pkg::ByteW-1:0]     out_payload_byte,
  output logic [spd_pkg::ByteW-1:0]     out_packet_type,
  output logic [spd_pkg::ByteW-1:0]     out_packet_length,
  output logic                          out_frame_end,
  output logic                          out_frame_status,
  output logic                          out_had_checksum
);

  // Sync word registers.
  logic [spd_pkg::WordW-1:0] sync_cs_r, sync_plain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_cs_r    <= spd_pkg::SyncChecksummedReset;
      sync_plain_r <= spd_pkg::SyncPlainReset;
    end else if (cfg_we) begin
      case (cfg_index)
        spd_pkg::RegSyncChecksummed: sync_cs_r    <= cfg_wdata;
        spd_pkg::RegSyncPlain:       sync_plain_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Framing state.
  spd_pkg::phase_t           phase_r, phase_nxt;
  logic [spd_pkg::ByteW-1:0] prev_byte_r, prev_byte_nxt;
  logic                      checksum_mode_r, checksum_mode_nxt;
  logic [1:0]                header_index_r, header_index_nxt;
  logic [spd_pkg::ByteW-1:0] type_r, type_nxt;
  logic [spd_pkg::ByteW-1:0] length_r, length_nxt;
  logic [spd_pkg::ByteW-1:0] bytes_left_r, bytes_left_nxt;
  logic [spd_pkg::WordW-1:0] expected_sum_r, expected_sum_nxt;
  logic [spd_pkg::WordW-1:0] running_sum_r, running_sum_nxt;

  logic                      in_accept;
  logic                      out_full;
  spd_pkg::res_t             res;
  spd_pkg::res_t             out_res;
  logic [spd_pkg::WordW-1:0] word;
  logic [1:0]                last_index;

  assign in_accept  = in_valid && !out_full;
  assign in_stall   = out_full;
  assign word       = {in_rx_byte, prev_byte_r};
  assign last_index = checksum_mode_r ? spd_pkg::HdrSumHigh : spd_pkg::HdrLength;

  always_comb begin
    phase_nxt         = phase_r;
    prev_byte_nxt     = prev_byte_r;
    checksum_mode_nxt = checksum_mode_r;
    header_index_nxt  = header_index_r;
    type_nxt          = type_r;
    length_nxt        = length_r;
    bytes_left_nxt    = bytes_left_r;
    expected_sum_nxt  = expected_sum_r;
    running_sum_nxt   = running_sum_r;
    res               = '0;

    case (phase_r)
      spd_pkg::PHASE_HEADER: begin
        case (header_index_r)
          spd_pkg::HdrType:    type_nxt = in_rx_byte;
          spd_pkg::HdrLength:  length_nxt = in_rx_byte;
          spd_pkg::HdrSumLow:  expected_sum_nxt = {8'h00, in_rx_byte};
          spd_pkg::HdrSumHigh: expected_sum_nxt = {in_rx_byte, expected_sum_r[7:0]};
          default: ;
        endcase
        if (header_index_r >= last_index) begin
          header_index_nxt = '0;
          if (length_nxt == '0) begin
            // Empty packet: closes on its last header byte.
            res.frame_end    = 1'b1;
            res.frame_status = checksum_mode_r && (expected_sum_nxt != '0);
            phase_nxt        = spd_pkg::PHASE_HUNT;
            prev_byte_nxt    = '0;
          end else begin
            bytes_left_nxt  = length_nxt;
            running_sum_nxt = '0;
            phase_nxt       = spd_pkg::PHASE_PAYLOAD;
          end
        end else begin
          header_index_nxt = header_index_r + 2'd1;
        end
      end
      spd_pkg::PHASE_PAYLOAD: begin
        res.payload_valid = 1'b1;
        res.payload_byte  = in_rx_byte;
        running_sum_nxt   = running_sum_r + {8'h00, in_rx_byte};
        bytes_left_nxt    = bytes_left_r - 8'd1;
        if (bytes_left_nxt == '0) begin
          res.frame_end    = 1'b1;
          res.frame_status = checksum_mode_r && (expected_sum_r != running_sum_nxt);
          phase_nxt        = spd_pkg::PHASE_HUNT;
          prev_byte_nxt    = '0;
        end
      end
      default: begin
        // Hunting: the checksummed sync wins when both registers match.
        prev_byte_nxt = in_rx_byte;
        if (word == sync_cs_r || word == sync_plain_r) begin
          checksum_mode_nxt = (word == sync_cs_r);
          phase_nxt         = spd_pkg::PHASE_HEADER;
          header_index_nxt  = '0;
          expected_sum_nxt  = '0;
          running_sum_nxt   = '0;
        end
      end
    endcase

    res.packet_type   = type_nxt;
    res.packet_length = length_nxt;
    res.had_checksum  = checksum_mode_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= spd_pkg::PHASE_HUNT;
      prev_byte_r     <= '0;
      checksum_mode_r <= 1'b0;
      header_index_r  <= '0;
      type_r          <= '0;
      length_r        <= '0;
      bytes_left_r    <= '0;
      expected_sum_r  <= '0;
      running_sum_r   <= '0;
    end else if (in_accept) begin
      phase_r         <= phase_nxt;
      prev_byte_r     <= prev_byte_nxt;
      checksum_mode_r <= checksum_mode_nxt;
      header_index_r  <= header_index_nxt;
      type_r          <= type_nxt;
      length_r        <= length_nxt;
      bytes_left_r    <= bytes_left_nxt;
      expected_sum_r  <= expected_sum_nxt;
      running_sum_r   <= running_sum_nxt;
    end
  end

  // Output stage: holds up to two results so a stalled receiver does not
  // immediately stall the link side.
  spd_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_accept),
    .push_data (res),
    .full      (out_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_res)
  );

  assign out_payload_valid = out_res.payload_valid;
  assign out_payload_byte  = out_res.payload_byte;
  assign out_packet_type   = out_res.packet_type;
  assign out_packet_length = out_res.packet_length;
  assign out_frame_end     = out_res.frame_end;
  assign out_frame_status  = out_res.frame_status;
  assign out_had_checksum  = out_res.had_checksum;

  // In the payload phase at least one byte is always still owed.
  `SPD_ASSERT(a_payload_not_empty, clk, rst_n,
    phase_r != spd_pkg::PHASE_PAYLOAD || bytes_left_r != '0,
    "payload phase with no bytes left")
  // A plain header never walks past its length byte.
  `SPD_ASSERT(a_plain_header_short, clk, rst_n,
    phase_r != spd_pkg::PHASE_HEADER || checksum_mode_r ||
    header_index_r == spd_pkg::HdrType || header_index_r == spd_pkg::HdrLength,
    "plain header index beyond length byte")
  // An accepted byte that closes a frame leaves the block hunting.
  `SPD_ASSERT_NEXT(a_end_to_hunt, clk, rst_n, in_accept && res.frame_end,
    phase_r == spd_pkg::PHASE_HUNT && prev_byte_r == '0,
    "frame end did not return to hunting")

endmodule
